// ----- rtl/core/bfba_pkg.sv -----
// Shared types and constants for the best-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bfba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // Field widths fixed by the interface
    localparam int CFG_W      = 5;
    localparam int SLOT_W     = 4;
    localparam int FIELD_W    = 16;
    localparam int SEQ_W      = 16;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    // Reset value of blocks_in_use
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] block_slot;
        logic [FIELD_W-1:0] size;
    } t_in_item;

    typedef struct packed {
        logic [SEQ_W-1:0]   request_number;
        logic               allocated;
        logic [SLOT_W-1:0]  block_index;
        logic [FIELD_W-1:0] remaining_size;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;    // write a block's free size from the input request
        logic start;   // latch request size and limit, clear best
        logic issue;   // read the next table entry
        logic finish;  // commit result and update chosen block
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic limit_zero;  // no block in use
        logic last_issue;  // current read address is the last in use
        logic out_free;    // output register can take a result
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/core/bfba_ctrl.sv -----
// Controller state machine for the best-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none

module bfba_ctrl
    import bfba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_kind,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_kind == KIND_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state = i_sts.limit_zero ? S_FINISH : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bfba_dpath.sv -----
// Datapath: free-size table, best-fit compare, sequence counter, output register.
`timescale 1ns / 1ps
`default_nettype none

module bfba_dpath
    import bfba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire t_in_item         i_in_data,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_out_ready,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);

    logic [SIZE_WIDTH-1:0] r_mem [NUM_BLOCKS];

    logic [CFG_W-1:0]      r_blocks_in_use;
    logic [CNT_W-1:0]      w_limit_eff;
    logic [CNT_W-1:0]      r_limit;
    logic [SIZE_WIDTH-1:0] r_size;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [SIZE_WIDTH-1:0] r_rd_data;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [SIZE_WIDTH-1:0] r_best_val;
    logic [SEQ_W-1:0]      r_count;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    logic                  w_take;
    logic                  w_fits;
    logic                  w_better;
    logic [SIZE_WIDTH-1:0] w_remain;
    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [SIZE_WIDTH-1:0] w_wr_data;
    logic                  w_slot_ok;

    // Blocks in use, clamped to the table depth
    assign w_limit_eff = (32'(r_blocks_in_use) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                             : CNT_W'(r_blocks_in_use);

    // Status
    assign o_sts.limit_zero = (w_limit_eff == '0);
    assign o_sts.last_issue = ((CNT_W'(r_addr) + CNT_W'(1)) == r_limit);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Best-fit compare; strict less keeps the lowest index on ties
    assign w_fits   = (r_rd_data >= r_size);
    assign w_better = !r_found || (r_rd_data < r_best_val);
    assign w_take   = r_rd_vld && w_fits && w_better;
    assign w_remain = r_best_val - r_size;

    // Single write port: loads in idle, update at finish
    assign w_slot_ok = (32'(i_in_data.block_slot) < NUM_BLOCKS);
    assign w_wr_en   = (i_cmd.load && w_slot_ok) || (i_cmd.finish && r_found);
    assign w_wr_addr = i_cmd.load ? IDX_W'(i_in_data.block_slot) : r_best_idx;
    assign w_wr_data = i_cmd.load ? SIZE_WIDTH'(i_in_data.size) : w_remain;

    // Table memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_addr];
        end
        r_rd_idx <= r_addr;
    end

    // Scan payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_size  <= SIZE_WIDTH'(i_in_data.size);
            r_limit <= w_limit_eff;
        end
        if (w_take) begin
            r_best_idx <= r_rd_idx;
            r_best_val <= r_rd_data;
        end
        if (i_cmd.finish) begin
            r_out_data.request_number <= r_count;
            r_out_data.allocated      <= r_found;
            r_out_data.block_index    <= r_found ? SLOT_W'(r_best_idx) : '0;
            r_out_data.remaining_size <= r_found ? FIELD_W'(w_remain) : '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= CFG_RESET;
            r_addr          <= '0;
            r_rd_vld        <= 1'b0;
            r_found         <= 1'b0;
            r_count         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_blocks_in_use <= i_cfg_data;
            end
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (w_take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_count != '1) begin
                    r_count <= r_count + SEQ_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- rtl/core/best_fit_block_allocator_unit.sv -----
// Top level of the best-fit block allocator.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_ready o_out_data (t_out_item)
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (blocks_in_use)
//
// A load request is written into the table as it is accepted. An allocation
// request passes through the accept step, one table read per block in use
// (blocks_in_use capped at 16) through the single read port, one compare drain
// and one commit step; with no block in use it goes straight to commit.
// Reset is synchronous and active low; the table is not cleared.
// A finished result waits in the output register; new requests are taken
// while it waits, and a following allocation stalls only at commit.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_block_allocator_unit
    import bfba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    bfba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    bfba_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Unallocated results carry zero index and size
    a_unalloc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.allocated) |->
            (o_out_data.block_index == '0 && o_out_data.remaining_size == '0))
        else $error("unallocated result with nonzero fields");

    // An accepted allocation request keeps the block busy next cycle
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.kind == KIND_REQ) |=> !o_in_ready)
        else $error("input ready right after allocation request");

    // Commit only happens when the output register can take it
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!o_out_valid || i_out_ready))
        else $error("result committed over a pending result");

endmodule

`default_nettype wire
